/* hw/rtl/anrd_pkg.sv */
// types, constants and helper functions shared by the nibble decoder files
`default_nettype none

package anrd_pkg;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 30;
  localparam int CRC_W    = 16;
  localparam int HASH_W   = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [CHAR_W-1:0] NIB_BASE   = 8'h47;  // 'G'
  localparam logic [CHAR_W-1:0] START_MARK = 8'h23;  // '#'
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h8f57;

  // register indexes on the config port
  localparam logic [1:0] REG_COUNT_HASH = 2'd0;
  localparam logic [1:0] REG_SPEED_HASH = 2'd1;
  localparam logic [1:0] REG_TIMER_HASH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COUNT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SPEED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMER  = 2'd3;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 30'd604066650;

  // one byte through the crc, msb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // decimal weight of a counter nibble, slot 0 is the least significant
  function automatic logic [VALUE_W-1:0] count_weight(input logic [2:0] slot);
    logic [VALUE_W-1:0] w;
    case (slot)
      3'd0:    w = 30'd1;
      3'd1:    w = 30'd10;
      3'd2:    w = 30'd100;
      3'd3:    w = 30'd1000;
      3'd4:    w = 30'd10000;
      3'd5:    w = 30'd100000;
      3'd6:    w = 30'd1000000;
      default: w = 30'd10000000;
    endcase
    return w;
  endfunction

  // millisecond weight of a timer nibble
  function automatic logic [VALUE_W-1:0] timer_weight(input logic [2:0] slot);
    logic [VALUE_W-1:0] w;
    case (slot)
      3'd0:    w = 30'd10;
      3'd1:    w = 30'd100;
      3'd2:    w = 30'd1000;
      3'd3:    w = 30'd10000;
      3'd4:    w = 30'd60000;
      3'd5:    w = 30'd600000;
      3'd6:    w = 30'd3600000;
      default: w = 30'd36000000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/anrd_if.sv */
// valid/ready channel interfaces for characters in and decoded responses out
`default_nettype none

interface anrd_char_if;
  logic                         valid;
  logic                         ready;
  logic [anrd_pkg::CHAR_W-1:0]  rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface anrd_resp_if;
  logic                          valid;
  logic                          ready;
  logic [anrd_pkg::STATUS_W-1:0] status;
  logic [anrd_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ascii_nibble_response_decoder.sv */
// Decoder for '#'-framed ASCII nibble responses with CRC-16 check. One character
// word is taken per clock; the frame state, CRC, hash bytes and the two decimal
// accumulators are updated in the cycle the character is accepted, so a
// terminator's response is in the output buffer in the cycle after it is accepted. Input
// ready only drops while the two-entry output buffer is full, so the sustained
// rate is one character per cycle whenever the response side keeps up.
`default_nettype none

module ascii_nibble_response_decoder #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  anrd_char_if.sink                     rx,
  anrd_resp_if.source                   resp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [anrd_pkg::PADDR_W-1:0]  paddr,
  input  logic [anrd_pkg::PDATA_W-1:0]  pwdata,
  output logic [anrd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import anrd_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME_BYTES + 1);

  // config registers
  logic [HASH_W-1:0] count_hash, speed_hash, timer_hash;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  // frame state
  logic              in_frame;
  logic              have_high_nibble;
  logic [3:0]        high_nibble;
  logic [CntW-1:0]   byte_count;
  logic [CRC_W-1:0]  running_crc;
  logic              frame_bad;
  logic [7:0]        hash_hi, hash_lo;
  logic [VALUE_W-1:0] count_acc, timer_acc;

  // output buffer, two words deep
  logic [1:0]          buf_cnt;
  logic [STATUS_W-1:0] head_status, skid_status;
  logic [VALUE_W-1:0]  head_value, skid_value;

  logic                accept, is_start, is_term, push, pop;
  logic [CHAR_W-1:0]   nib_full;
  logic                bad_char;
  logic [7:0]          byte_val;
  logic [CRC_W-1:0]    crc_next;
  logic [1:0]          cnt_slot, tmr_slot;
  logic                in_count_span, in_timer_span, overflow;
  logic [VALUE_W-1:0]  count_term, timer_term;
  logic                bad_fin, base_ok;
  logic [HASH_W-1:0]   frame_hash;
  logic [STATUS_W-1:0] new_status;
  logic [VALUE_W-1:0]  new_value;

  // ---------------- config port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_COUNT_HASH: prdata = PDATA_W'(count_hash);
      REG_SPEED_HASH: prdata = PDATA_W'(speed_hash);
      REG_TIMER_HASH: prdata = PDATA_W'(timer_hash);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_hash <= '0;
      speed_hash <= '0;
      timer_hash <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COUNT_HASH: count_hash <= pwdata[HASH_W-1:0];
        REG_SPEED_HASH: speed_hash <= pwdata[HASH_W-1:0];
        REG_TIMER_HASH: timer_hash <= pwdata[HASH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- character decode ----------------
  assign rx.ready = (buf_cnt != 2'd2);
  assign accept   = rx.valid & rx.ready;
  assign is_start = (rx.rx_char == START_MARK);
  assign is_term  = (rx.rx_char == CHAR_CR) || (rx.rx_char == CHAR_LF) ||
                    (rx.rx_char == CHAR_NUL);
  assign nib_full = rx.rx_char - NIB_BASE;
  assign bad_char = |nib_full[7:4];
  assign byte_val = {high_nibble, nib_full[3:0]};
  assign crc_next = crc_byte(running_crc, byte_val);
  assign overflow = (byte_count >= CntW'(MAX_FRAME_BYTES));

  // bytes 4..7 feed the counter sum, bytes 6..9 the timer sum
  assign in_count_span = (byte_count >= CntW'(4)) && (byte_count <= CntW'(7));
  assign in_timer_span = (byte_count >= CntW'(6)) && (byte_count <= CntW'(9));
  assign cnt_slot      = 2'(CntW'(7) - byte_count);
  assign tmr_slot      = 2'(CntW'(9) - byte_count);

  assign count_term = VALUE_W'(nib_full[3:0]) * count_weight({cnt_slot, 1'b0}) +
                      VALUE_W'(high_nibble)   * count_weight({cnt_slot, 1'b1});
  assign timer_term = VALUE_W'(nib_full[3:0]) * timer_weight({tmr_slot, 1'b0}) +
                      VALUE_W'(high_nibble)   * timer_weight({tmr_slot, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      have_high_nibble <= 1'b0;
      high_nibble      <= '0;
      byte_count       <= '0;
      running_crc      <= '0;
      frame_bad        <= 1'b0;
      count_acc        <= '0;
      timer_acc        <= '0;
    end else if (accept) begin
      if (is_start) begin
        in_frame         <= 1'b1;
        have_high_nibble <= 1'b0;
        high_nibble      <= '0;
        byte_count       <= '0;
        running_crc      <= '0;
        frame_bad        <= 1'b0;
        count_acc        <= '0;
        timer_acc        <= '0;
      end else if (in_frame) begin
        if (is_term) begin
          in_frame         <= 1'b0;
          have_high_nibble <= 1'b0;
        end else begin
          if (bad_char) begin
            frame_bad <= 1'b1;
          end
          if (!have_high_nibble) begin
            high_nibble      <= nib_full[3:0];
            have_high_nibble <= 1'b1;
          end else begin
            have_high_nibble <= 1'b0;
            if (overflow) begin
              frame_bad <= 1'b1;
            end else begin
              running_crc <= crc_next;
              byte_count  <= byte_count + CntW'(1);
              if (in_count_span) begin
                count_acc <= count_acc + count_term;
              end
              if (in_timer_span) begin
                timer_acc <= timer_acc + timer_term;
              end
            end
          end
        end
      end
    end
  end

  // hash bytes are only read after a frame that reached four bytes
  always_ff @(posedge clk) begin
    if (accept && !is_start && in_frame && !is_term && have_high_nibble && !overflow) begin
      if (byte_count == CntW'(2)) begin
        hash_hi <= byte_val;
      end
      if (byte_count == CntW'(3)) begin
        hash_lo <= byte_val;
      end
    end
  end

  // ---------------- frame verdict ----------------
  assign bad_fin    = frame_bad | have_high_nibble;
  assign base_ok    = !bad_fin && (byte_count >= CntW'(4)) && (running_crc == '0);
  assign frame_hash = {hash_hi, hash_lo};

  always_comb begin
    new_status = ST_REJECT;
    new_value  = '0;
    if (base_ok) begin
      if (frame_hash == count_hash) begin
        if (byte_count >= CntW'(8)) begin
          new_status = ST_COUNT;
          new_value  = count_acc;
        end
      end else if (frame_hash == speed_hash) begin
        if (byte_count >= CntW'(8)) begin
          new_status = ST_SPEED;
          new_value  = count_acc;
        end
      end else if (frame_hash == timer_hash) begin
        if (byte_count >= CntW'(10)) begin
          new_status = ST_TIMER;
          new_value  = timer_acc;
        end
      end
    end
  end

  // ---------------- output buffer ----------------
  assign push = accept && !is_start && in_frame && is_term;
  assign pop  = resp.valid & resp.ready;

  assign resp.valid  = (buf_cnt != 2'd0);
  assign resp.status = head_status;
  assign resp.value  = head_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else begin
      buf_cnt <= buf_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if ((buf_cnt == 2'd0 && push) || (buf_cnt == 2'd1 && pop && push)) begin
      head_status <= new_status;
      head_value  <= new_value;
    end else if (buf_cnt == 2'd2 && pop) begin
      head_status <= skid_status;
      head_value  <= skid_value;
    end
    if (buf_cnt == 2'd1 && push && !pop) begin
      skid_status <= new_status;
      skid_value  <= new_value;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/anrd_checker.sv */
// port-level checks for the nibble response decoder, bound to the top level
`default_nettype none

module anrd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          resp_valid,
  input logic                          resp_ready,
  input logic [anrd_pkg::STATUS_W-1:0] status,
  input logic [anrd_pkg::VALUE_W-1:0]  value
);
  import anrd_pkg::*;

  // a stalled response word holds
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(status) && $stable(value))
    else $error("response word changed while stalled");

  // rejected frames report a zero reading
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && status == ST_REJECT |-> value == '0)
    else $error("rejected response with nonzero value");

  // readings stay inside the decimal range
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> value <= VALUE_MAX)
    else $error("response value out of range");

  // a new response needs a character accepted the cycle before
  a_resp_cause: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !$past(resp_valid) && !$past(rst) |-> $past(in_valid && in_ready))
    else $error("response appeared without an accepted character");

endmodule

bind ascii_nibble_response_decoder anrd_checker u_anrd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (rx.valid),
  .in_ready   (rx.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .status     (resp.status),
  .value      (resp.value)
);

`default_nettype wire

/* verif/ascii_nibble_response_decoder_tb.sv */
// testbench for the ascii nibble response decoder: framed character traffic checked per response
`timescale 1ns / 100ps

module ascii_nibble_response_decoder_tb;
  import anrd_pkg::*;

  localparam int FRAME_MAX  = 32;
  localparam int STORE_N    = 10;
  localparam int SETTLE     = 6;
  localparam int RAND_CHARS = 1000;
  localparam int DEC_W [8] = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000};
  localparam int MS_W [8]  = '{10, 100, 1000, 10000, 60000, 600000, 3600000, 36000000};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value;
  } reply_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;

  anrd_char_if rx_if ();
  anrd_resp_if resp_if ();

  ascii_nibble_response_decoder #(.MAX_FRAME_BYTES(FRAME_MAX)) dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_if),
    .resp(resp_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // mirrored hash registers and frame state
  logic [15:0] cfg_count;
  logic [15:0] cfg_speed;
  logic [15:0] cfg_timer;
  logic        fr_open;
  logic        fr_half;
  logic        fr_bad;
  logic [3:0]  fr_hi;
  int          fr_len;
  logic [15:0] fr_crc;
  logic [7:0]  fr_store [STORE_N];

  reply_t     due_replies [$];
  logic [7:0] pay_q [$];
  logic [7:0] line_q [$];

  bit rx_steady;
  bit resp_steady;
  int errors = 0;
  int n_chars = 0;
  int n_replies = 0;
  int n_status [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : run_limit
    #5_000_000;
    $display("run limit reached");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ b[i]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // four stored bytes from top downward, low nibble before high nibble
  function automatic logic [VALUE_W-1:0] weigh(input int top, input bit in_ms);
    logic [31:0] sum;
    logic [7:0]  b;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      b = fr_store[top - i];
      sum += 32'(b[3:0]) * 32'(in_ms ? MS_W[2*i] : DEC_W[2*i]);
      sum += 32'(b[7:4]) * 32'(in_ms ? MS_W[2*i+1] : DEC_W[2*i+1]);
    end
    return sum[VALUE_W-1:0];
  endfunction

  function automatic reply_t close_frame();
    reply_t      r;
    logic [15:0] h;
    r.status = ST_REJECT;
    r.value  = '0;
    if (!fr_bad && fr_len >= 4 && fr_crc == 16'h0000) begin
      h = {fr_store[2], fr_store[3]};
      // a matching hash with too few bytes does not fall through to the next one
      if (h == cfg_count) begin
        if (fr_len >= 8) begin
          r.status = ST_COUNT;
          r.value  = weigh(7, 1'b0);
        end
      end else if (h == cfg_speed) begin
        if (fr_len >= 8) begin
          r.status = ST_SPEED;
          r.value  = weigh(7, 1'b0);
        end
      end else if (h == cfg_timer) begin
        if (fr_len >= 10) begin
          r.status = ST_TIMER;
          r.value  = weigh(9, 1'b1);
        end
      end
    end
    return r;
  endfunction

  function automatic void decode_rx_char(input logic [7:0] c);
    logic [7:0] off;
    logic [7:0] b;
    if (c == START_MARK) begin
      fr_open = 1'b1;
      fr_half = 1'b0;
      fr_hi   = '0;
      fr_len  = 0;
      fr_crc  = '0;
      fr_bad  = 1'b0;
      return;
    end
    if (!fr_open) begin
      return;
    end
    if (c == CHAR_CR || c == CHAR_LF || c == CHAR_NUL) begin
      if (fr_half) begin
        fr_bad = 1'b1;
      end
      due_replies.push_back(close_frame());
      fr_open = 1'b0;
      fr_half = 1'b0;
      return;
    end
    off = c - NIB_BASE;
    if (off[7:4] != 4'h0) begin
      fr_bad = 1'b1;
    end
    if (!fr_half) begin
      fr_hi   = off[3:0];
      fr_half = 1'b1;
      return;
    end
    fr_half = 1'b0;
    // pairs past the frame limit are dropped and spoil the frame
    if (fr_len >= FRAME_MAX) begin
      fr_bad = 1'b1;
      return;
    end
    b = {fr_hi, off[3:0]};
    if (fr_len < STORE_N) begin
      fr_store[fr_len] = b;
    end
    fr_crc = crc_add(fr_crc, b);
    fr_len++;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return NIB_BASE + {4'h0, n};
  endfunction

  function automatic logic [7:0] pick_term();
    case ($urandom_range(0, 2))
      0: return CHAR_CR;
      1: return CHAR_LF;
      default: return CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return nib_char(4'($urandom));
      3: return pick_term();
      4: return START_MARK;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void load_reading(input logic [15:0] hash, input int len, input bit bcd);
    pay_q.delete();
    for (int i = 0; i < len; i++) begin
      if (bcd) begin
        pay_q.push_back({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
      end else begin
        pay_q.push_back(8'($urandom));
      end
    end
    if (len >= 4) begin
      pay_q[2] = hash[15:8];
      pay_q[3] = hash[7:0];
    end
  endfunction

  function automatic void frame_chars(input bit crc_ok, input logic [7:0] term);
    logic [15:0] crc;
    crc = '0;
    line_q.push_back(START_MARK);
    foreach (pay_q[i]) begin
      crc = crc_add(crc, pay_q[i]);
      line_q.push_back(nib_char(pay_q[i][7:4]));
      line_q.push_back(nib_char(pay_q[i][3:0]));
    end
    // appending the crc high byte first brings the running crc back to zero
    if (!crc_ok) begin
      crc ^= 16'(1 << $urandom_range(0, 15));
    end
    for (int k = 3; k >= 0; k--) begin
      line_q.push_back(nib_char(crc[4*k +: 4]));
    end
    line_q.push_back(term);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = rx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_char <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_char <= c;
    do @(posedge clk); while (!rx_if.ready);
    decode_rx_char(c);
    n_chars++;
  endtask

  task automatic send_line();
    rx_steady   = ($urandom_range(0, 4) == 0);
    resp_steady = ($urandom_range(0, 4) == 0);
    foreach (line_q[i]) begin
      send_char(line_q[i]);
    end
    line_q.delete();
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0000, data};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [15:0] want, input string name);
    logic [PDATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== {16'h0000, want}) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  task automatic drain_replies();
    int waited;
    rx_if.valid <= 1'b0;
    waited = 0;
    while (due_replies.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (due_replies.size() != 0) begin
      $error("%0d responses never arrived", due_replies.size());
      errors++;
      due_replies.delete();
    end
  endtask

  task automatic program_hashes(input logic [15:0] c, input logic [15:0] s,
                                input logic [15:0] t);
    drain_replies();
    apb_write(REG_COUNT_HASH, c);
    apb_write(REG_SPEED_HASH, s);
    apb_write(REG_TIMER_HASH, t);
    cfg_count = c;
    cfg_speed = s;
    cfg_timer = t;
    check_reg(REG_COUNT_HASH, c, "count_hash");
    check_reg(REG_SPEED_HASH, s, "speed_hash");
    check_reg(REG_TIMER_HASH, t, "timer_hash");
  endtask

  task automatic random_frame();
    logic [15:0] hash;
    logic [7:0]  term;
    int          kind;
    int          len;
    int          keep;
    kind = $urandom_range(0, 15);
    case ($urandom_range(0, 3))
      0: hash = cfg_count;
      1: hash = cfg_speed;
      2: hash = cfg_timer;
      default: hash = 16'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0: len = $urandom_range(0, 3);
      1: len = $urandom_range(FRAME_MAX - 4, FRAME_MAX);
      default: len = $urandom_range(6, 12);
    endcase
    load_reading(hash, len, 1'($urandom_range(0, 1)));
    term = pick_term();
    if (kind == 12) begin
      // abandoned partial frame right before a new start mark
      line_q.push_back(START_MARK);
      repeat ($urandom_range(0, 6)) line_q.push_back(nib_char(4'($urandom)));
    end else if (kind >= 13) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(noise_char());
    end
    frame_chars(!(kind == 9 || $urandom_range(0, 31) == 0), term);
    if (kind == 10) begin
      line_q[$urandom_range(1, line_q.size() - 2)] = noise_char();
    end else if (kind == 11) begin
      // cut after an odd count of nibbles so the terminator splits a pair
      keep = $urandom_range(1, 2 * len + 3) | 1;
      while (line_q.size() > keep + 1) begin
        void'(line_q.pop_back());
      end
      line_q.push_back(term);
    end
    send_line();
  endtask

  task automatic test_register_access();
    check_reg(REG_COUNT_HASH, 16'h0000, "count_hash");
    check_reg(REG_SPEED_HASH, 16'h0000, "speed_hash");
    check_reg(REG_TIMER_HASH, 16'h0000, "timer_hash");
    program_hashes(16'hffff, 16'h0000, 16'h8001);
    program_hashes(16'h0000, 16'hffff, 16'h7ffe);
  endtask

  task automatic test_directed_frames();
    logic [7:0] bad [3] = '{8'hff, 8'h46, 8'h57};
    program_hashes(16'h1234, 16'h5678, 16'h9abc);
    // largest decimal counter reading
    load_reading(16'h1234, 8, 1'b1);
    for (int i = 4; i < 8; i++) pay_q[i] = 8'h99;
    frame_chars(1'b1, CHAR_CR);
    send_line();
    load_reading(16'h5678, 12, 1'b1);
    for (int i = 4; i < 8; i++) pay_q[i] = 8'h00;
    frame_chars(1'b1, CHAR_LF);
    send_line();
    // all-ones timer nibbles give the largest value
    load_reading(16'h9abc, 10, 1'b0);
    for (int i = 6; i < 10; i++) pay_q[i] = 8'hff;
    frame_chars(1'b1, CHAR_NUL);
    send_line();
    load_reading(16'h1234, 8, 1'b0);
    for (int i = 4; i < 8; i++) pay_q[i] = 8'hff;
    frame_chars(1'b1, CHAR_CR);
    send_line();
    load_reading(16'h1234, 8, 1'b1);
    frame_chars(1'b0, CHAR_CR);
    send_line();
    load_reading(16'h4321, 10, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    // empty frame and frames too short for their hash
    line_q.push_back(START_MARK);
    line_q.push_back(CHAR_CR);
    send_line();
    load_reading(16'h1234, 4, 1'b1);
    frame_chars(1'b1, CHAR_LF);
    send_line();
    load_reading(16'h9abc, 6, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    foreach (bad[i]) begin
      load_reading(16'h1234, 8, 1'b1);
      frame_chars(1'b1, CHAR_CR);
      line_q[3] = bad[i];
      send_line();
    end
    load_reading(16'h1234, 8, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    while (line_q.size() > 6) begin
      void'(line_q.pop_back());
    end
    line_q.push_back(CHAR_LF);
    send_line();
    // junk outside any frame, then a dropped partial frame, then a clean one
    line_q = '{CHAR_CR, CHAR_LF, CHAR_NUL, 8'hff, 8'h80, NIB_BASE,
               START_MARK, NIB_BASE, nib_char(4'h1), nib_char(4'h2)};
    frame_chars(1'b1, CHAR_NUL);
    send_line();
    // exactly at the byte limit, then one byte past it
    load_reading(16'h1234, FRAME_MAX - 2, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    load_reading(16'h1234, FRAME_MAX - 1, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    load_reading(16'h9abc, FRAME_MAX + 2, 1'b1);
    frame_chars(1'b1, CHAR_LF);
    send_line();
  endtask

  task automatic test_hash_priority();
    program_hashes(16'h0f0f, 16'h0f0f, 16'h0f0f);
    load_reading(16'h0f0f, 10, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    program_hashes(16'h1111, 16'h2222, 16'h2222);
    load_reading(16'h2222, 10, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    program_hashes(16'h3333, 16'h4444, 16'h3333);
    load_reading(16'h3333, 4, 1'b1);
    frame_chars(1'b1, CHAR_CR);
    send_line();
    load_reading(16'h3333, 6, 1'b1);
    frame_chars(1'b1, CHAR_LF);
    send_line();
  endtask

  task automatic test_random_traffic();
    logic [15:0] a;
    logic [15:0] b;
    int          stop_at;
    for (int ph = 0; ph < 6; ph++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (ph)
        0: program_hashes(a, b, 16'($urandom));
        1: program_hashes(16'h0000, 16'hffff, a);
        2: program_hashes(16'hffff, a, 16'h0000);
        3: program_hashes(a, a, a);
        4: program_hashes(a, b, b);
        default: program_hashes(b, a, 16'($urandom));
      endcase
      stop_at = n_chars + RAND_CHARS / 6;
      while (n_chars < stop_at) begin
        random_frame();
      end
    end
  endtask

  initial begin : reply_sink
    int gap;
    resp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = resp_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        resp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      resp_if.ready <= 1'b1;
      do @(posedge clk); while (!resp_if.valid);
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && resp_if.valid && resp_if.ready) begin
      if (due_replies.size() == 0) begin
        $error("response word with none outstanding: status %0d value %0d",
               resp_if.status, resp_if.value);
        errors++;
      end else begin
        want = due_replies.pop_front();
        if (resp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, resp_if.status);
          errors++;
        end
        if (resp_if.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, resp_if.value);
          errors++;
        end
        n_replies++;
        n_status[want.status]++;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_char <= '0;
    cfg_count = '0;
    cfg_speed = '0;
    cfg_timer = '0;
    fr_open   = 1'b0;
    fr_half   = 1'b0;
    fr_bad    = 1'b0;
    fr_hi     = '0;
    fr_len    = 0;
    fr_crc    = '0;
    foreach (fr_store[i]) fr_store[i] = '0;
    foreach (n_status[i]) n_status[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_frames();
    test_hash_priority();
    test_random_traffic();
    drain_replies();
    $display("%0d characters sent, %0d responses checked (%0d rejected, %0d counter,",
             n_chars, n_replies, n_status[ST_REJECT], n_status[ST_COUNT]);
    $display("  %0d speed, %0d timer) over twelve hash settings with stalls on both sides",
             n_status[ST_SPEED], n_status[ST_TIMER]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/anrd_pkg.sv
hw/rtl/anrd_if.sv
hw/rtl/ascii_nibble_response_decoder.sv
hw/rtl/anrd_checker.sv
verif/ascii_nibble_response_decoder_tb.sv
